// ===== rtl/sqvg_pkg.sv =====
package sqvg_pkg;

  localparam int DATA_W           = 32;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int MAX_STEPS        = 30;
  localparam int TURN_W           = 32;
  localparam int TRIG_W           = 32;

  // Inverse CORDIC gain (1/K), Q2.30
  localparam logic signed [TRIG_W-1:0] CORDIC_K = 32'sd652032874;

  // floor(u / 45) for 32-bit unsigned u: (u * DIV45_M) >> DIV45_SH
  localparam logic [32:0] DIV45_M  = 33'd6108397933;
  localparam int          DIV45_SH = 38;
  localparam int          QU_W     = 27;
  // 2^31 = 45 * OFS_Q + OFS_R
  localparam logic [QU_W-1:0] OFS_Q = 27'd47721858;
  localparam logic [5:0]      OFS_R = 6'd38;
  localparam logic [5:0]      DIV_N = 6'd45;

  typedef logic [1:0] corner_t;
  localparam corner_t LAST_CORNER = 2'd3;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [TURN_W-1:0] atan_turn(input int i);
    logic [TURN_W-1:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sqvg_if.sv =====
interface sqvg_in_if import sqvg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] size_x;
  logic signed [DATA_W-1:0] size_y;
  logic signed [DATA_W-1:0] pivot_x;
  logic signed [DATA_W-1:0] pivot_y;
  logic signed [DATA_W-1:0] angle_deg;

  modport source (output valid, pos_x, pos_y, size_x, size_y, pivot_x, pivot_y, angle_deg,
                  input ready);
  modport sink (input valid, pos_x, pos_y, size_x, size_y, pivot_x, pivot_y, angle_deg,
                output ready);
endinterface

interface sqvg_out_if import sqvg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] vertex_x;
  logic signed [DATA_W-1:0] vertex_y;
  corner_t                  corner;
  logic                     last;

  modport source (output valid, vertex_x, vertex_y, corner, last, input ready);
  modport sink (input valid, vertex_x, vertex_y, corner, last, output ready);
endinterface

// ===== rtl/sqvg_cordic.sv =====
module sqvg_cordic import sqvg_pkg::*; #(
  parameter int NSTEP = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [TURN_W-3:0]        z_in,
  output logic signed [TRIG_W-1:0] x_out,
  output logic signed [TRIG_W-1:0] y_out
);

  logic signed [TRIG_W-1:0] x_r [NSTEP];
  logic signed [TRIG_W-1:0] y_r [NSTEP];
  logic signed [TURN_W-1:0] z_r [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_stage
    logic signed [TRIG_W-1:0] xi;
    logic signed [TRIG_W-1:0] yi;
    logic signed [TURN_W-1:0] zi;

    if (i == 0) begin : g_first
      assign xi = CORDIC_K;
      assign yi = '0;
      assign zi = signed'(TURN_W'(z_in));
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[TURN_W-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - signed'(atan_turn(i));
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + signed'(atan_turn(i));
        end
      end
    end
  end

  assign x_out = x_r[NSTEP-1];
  assign y_out = y_r[NSTEP-1];

endmodule

// ===== rtl/sqvg_mul_q30.sv =====
module sqvg_mul_q30 import sqvg_pkg::*; #(
  parameter int DW = 48
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DW-1:0]     d,
  input  logic signed [TRIG_W-1:0] t,
  output logic signed [DW:0]       p
);

  localparam int MW = DW - 1;      // |d| magnitude bits
  localparam int HW = MW - 24 + TRIG_W;

  logic [MW-1:0]     m;
  logic [TRIG_W-1:0] n;
  logic [HW-1:0]     hi_r;
  logic [55:0]       lo_r;
  logic              neg_r;
  logic [56:0]       low;
  logic [DW-1:0]     mag;

  assign m = d[DW-1] ? MW'(-d) : MW'(d);
  assign n = t[TRIG_W-1] ? TRIG_W'(-t) : TRIG_W'(t);

  // split product: upper part of |d| and low 24 bits
  always_ff @(posedge clk) begin
    if (en) begin
      hi_r  <= HW'(m[MW-1:24]) * HW'(n);
      lo_r  <= 56'(m[23:0]) * 56'(n);
      neg_r <= d[DW-1] ^ t[TRIG_W-1];
    end
  end

  assign low = {27'(hi_r[5:0]), 24'b0} + 57'(lo_r) + (57'd1 << 29);
  assign mag = DW'(hi_r >> 6) + DW'(low >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg_r ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
  end

endmodule

// ===== rtl/sprite_quad_vertex_gen_core.sv =====
// Channel   Dir  Payload                                          Handshake
// in_ch     in   pos/size/pivot x,y, angle_deg (signed Q.F)       valid/ready
// out_ch    out  vertex_x, vertex_y (Q.F, saturated), corner, last valid/ready
//
// One sprite in, four corner beats out, one beat per cycle while out_ch is not
// stalled; the corner serializer takes the next sprite as the last corner moves on.
// NSTEP is CORDIC_STEPS capped at 30. Corners pass S1-S3, the CORDIC pipeline
// (one stage per micro-rotation), S4, the multiplier stages, S7 and the output
// register; the CORDIC pipeline dominates the latency.
// Reset (rst_n, synchronous) clears only valid bits and serializer state.
// Every stage holds when the output register is full and not taken.
module sprite_quad_vertex_gen_core import sqvg_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sqvg_in_if.sink    in_ch,
  sqvg_out_if.source out_ch
);

  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int SH    = TURN_W - FRAC_BITS;   // degrees Q.F -> turn scale shift
  localparam int DW    = 64 - FRAC_BITS;       // width of rounded offsets
  localparam int SW    = DW + 3;               // vertex sum width
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [DW-1:0]     dx;
    logic signed [DW-1:0]     dy;
    logic signed [DW-1:0]     ox;
    logic signed [DW-1:0]     oy;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    quad_t                    quad;
    corner_t                  corner;
  } side_t;

  // whole pipeline moves together whenever the output slot frees up
  logic adv;
  logic out_v_r;
  assign adv = !out_v_r || out_ch.ready;

  // ---------------- corner serializer ----------------
  logic                     hold_v_r;
  corner_t                  cnt_r;
  logic signed [DATA_W-1:0] h_px_r, h_py_r, h_wx_r, h_wy_r, h_vx_r, h_vy_r, h_ang_r;
  logic                     take;

  assign in_ch.ready = !hold_v_r || (adv && cnt_r == LAST_CORNER);
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      cnt_r    <= '0;
    end else if (take) begin
      hold_v_r <= 1'b1;
      cnt_r    <= '0;
    end else if (adv && hold_v_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == LAST_CORNER) hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h_px_r  <= in_ch.pos_x;
      h_py_r  <= in_ch.pos_y;
      h_wx_r  <= in_ch.size_x;
      h_wy_r  <= in_ch.size_y;
      h_vx_r  <= in_ch.pivot_x;
      h_vy_r  <= in_ch.pivot_y;
      h_ang_r <= in_ch.angle_deg;
    end
  end

  // ---------------- S1: pivot products, angle / 45 ----------------
  logic                     s1_v_r;
  logic [QU_W-1:0]          s1_qu_r;
  logic [DATA_W-1:0]        s1_u_r;
  logic signed [63:0]       s1_o2x_r, s1_o2y_r;
  logic signed [DATA_W-1:0] s1_wx_r, s1_wy_r, s1_px_r, s1_py_r;
  corner_t                  s1_corner_r;
  logic [DATA_W-1:0]        u;
  logic [64:0]              div_prod;

  // angle offset by 2^31 so the divide by 45 is unsigned
  assign u        = h_ang_r ^ {1'b1, {(DATA_W-1){1'b0}}};
  assign div_prod = 65'(u) * 65'(DIV45_M);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= hold_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_qu_r     <= div_prod[DIV45_SH +: QU_W];
      s1_u_r      <= u;
      s1_o2x_r    <= 64'(h_vx_r) * 64'(h_wx_r);
      s1_o2y_r    <= 64'(h_vy_r) * 64'(h_wy_r);
      s1_wx_r     <= h_wx_r;
      s1_wy_r     <= h_wy_r;
      s1_px_r     <= h_px_r;
      s1_py_r     <= h_py_r;
      s1_corner_r <= cnt_r;
    end
  end

  // ---------------- S2: signed quotient/remainder, corner offsets ----------------
  logic                     s2_v_r;
  logic signed [QU_W:0]     s2_q1_r;
  logic [5:0]               s2_r1_r;
  logic signed [63:0]       s2_dx2_r, s2_dy2_r;
  logic signed [DW-1:0]     s2_ox_r, s2_oy_r;
  logic signed [DATA_W-1:0] s2_px_r, s2_py_r;
  corner_t                  s2_corner_r;
  logic [5:0]               ru;
  logic                     ru_lo;
  logic signed [QU_W:0]     q1_nxt;
  logic [5:0]               r1_nxt;
  logic signed [63:0]       hwx, hwy;
  logic                     negx, negy;

  assign ru     = 6'(s1_u_r - DATA_W'(s1_qu_r) * DATA_W'(DIV_N));
  assign ru_lo  = ru < OFS_R;
  assign q1_nxt = signed'({1'b0, s1_qu_r}) - signed'({1'b0, OFS_Q})
                  - signed'((QU_W+1)'(ru_lo));
  assign r1_nxt = ru_lo ? ru + (DIV_N - OFS_R) : ru - OFS_R;

  // corner order (-,-) (+,-) (+,+) (-,+)
  assign negx = (s1_corner_r == 2'd0) || (s1_corner_r == LAST_CORNER);
  assign negy = !s1_corner_r[1];
  assign hwx  = 64'(s1_wx_r) <<< (FRAC_BITS - 1);
  assign hwy  = 64'(s1_wy_r) <<< (FRAC_BITS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_q1_r     <= q1_nxt;
      s2_r1_r     <= r1_nxt;
      s2_dx2_r    <= (negx ? -hwx : hwx) - s1_o2x_r;
      s2_dy2_r    <= (negy ? -hwy : hwy) - s1_o2y_r;
      s2_ox_r     <= DW'((s1_o2x_r + HALF) >>> FRAC_BITS);
      s2_oy_r     <= DW'((s1_o2y_r + HALF) >>> FRAC_BITS);
      s2_px_r     <= s1_px_r;
      s2_py_r     <= s1_py_r;
      s2_corner_r <= s1_corner_r;
    end
  end

  // ---------------- S3: binary angle, rounded corner deltas ----------------
  logic              s3_v_r;
  logic [TURN_W-1:0] s3_turn_r;
  side_t             s3_side_r;
  logic [TURN_W-1:0] frac_turn;
  logic [TURN_W-1:0] turn_nxt;

  // round((r1 * 2^SH) / 360) for the 45 possible remainders
  always_comb begin
    frac_turn = '0;
    for (int i = 0; i < 45; i++) begin
      if (s2_r1_r == 6'(i)) begin
        frac_turn = TURN_W'(((longint'(i) <<< SH) + 180) / 360);
      end
    end
  end

  assign turn_nxt = (TURN_W'(s2_q1_r) << (SH - 3)) + frac_turn;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_turn_r        <= turn_nxt;
      s3_side_r.dx     <= DW'((s2_dx2_r + HALF) >>> FRAC_BITS);
      s3_side_r.dy     <= DW'((s2_dy2_r + HALF) >>> FRAC_BITS);
      s3_side_r.ox     <= s2_ox_r;
      s3_side_r.oy     <= s2_oy_r;
      s3_side_r.px     <= s2_px_r;
      s3_side_r.py     <= s2_py_r;
      s3_side_r.quad   <= quad_t'(turn_nxt[TURN_W-1 -: 2]);
      s3_side_r.corner <= s2_corner_r;
    end
  end

  // ---------------- CORDIC, side data delayed alongside ----------------
  logic signed [TRIG_W-1:0] cx, cy;
  side_t                    line_r [NSTEP];
  logic                     line_v_r [NSTEP];

  sqvg_cordic #(.NSTEP(NSTEP)) u_cordic (
    .clk   (clk),
    .en    (adv),
    .z_in  (s3_turn_r[TURN_W-3:0]),
    .x_out (cx),
    .y_out (cy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTEP; i++) line_v_r[i] <= 1'b0;
    end else if (adv) begin
      line_v_r[0] <= s3_v_r;
      for (int i = 1; i < NSTEP; i++) line_v_r[i] <= line_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_r[0] <= s3_side_r;
      for (int i = 1; i < NSTEP; i++) line_r[i] <= line_r[i-1];
    end
  end

  // ---------------- S4: quadrant mapping ----------------
  logic                     s4_v_r;
  side_t                    s4_side_r;
  logic signed [TRIG_W-1:0] s4_c_r, s4_s_r;
  logic signed [TRIG_W-1:0] c_nxt, s_nxt;

  always_comb begin
    case (line_r[NSTEP-1].quad)
      QUAD_0:  begin c_nxt = cx;  s_nxt = cy;  end
      QUAD_1:  begin c_nxt = -cy; s_nxt = cx;  end
      QUAD_2:  begin c_nxt = -cx; s_nxt = -cy; end
      default: begin c_nxt = cy;  s_nxt = -cx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= line_v_r[NSTEP-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side_r <= line_r[NSTEP-1];
      s4_c_r    <= c_nxt;
      s4_s_r    <= s_nxt;
    end
  end

  // ---------------- rotation products (two stages) ----------------
  logic signed [DW:0] p_xc, p_ys, p_xs, p_yc;
  logic               ma_v_r, mb_v_r;
  side_t              ma_side_r, mb_side_r;

  sqvg_mul_q30 #(.DW(DW)) u_mul_xc (
    .clk(clk), .en(adv), .d(s4_side_r.dx), .t(s4_c_r), .p(p_xc));
  sqvg_mul_q30 #(.DW(DW)) u_mul_ys (
    .clk(clk), .en(adv), .d(s4_side_r.dy), .t(s4_s_r), .p(p_ys));
  sqvg_mul_q30 #(.DW(DW)) u_mul_xs (
    .clk(clk), .en(adv), .d(s4_side_r.dx), .t(s4_s_r), .p(p_xs));
  sqvg_mul_q30 #(.DW(DW)) u_mul_yc (
    .clk(clk), .en(adv), .d(s4_side_r.dy), .t(s4_c_r), .p(p_yc));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_v_r <= 1'b0;
      mb_v_r <= 1'b0;
    end else if (adv) begin
      ma_v_r <= s4_v_r;
      mb_v_r <= ma_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_side_r <= s4_side_r;
      mb_side_r <= ma_side_r;
    end
  end

  // ---------------- S7: vertex sums ----------------
  logic                 s7_v_r;
  logic signed [SW-1:0] s7_rx_r, s7_ry_r;
  corner_t              s7_corner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= mb_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_rx_r     <= SW'(p_xc) - SW'(p_ys) + SW'(mb_side_r.ox) + SW'(mb_side_r.px);
      s7_ry_r     <= SW'(p_xs) + SW'(p_yc) + SW'(mb_side_r.oy) + SW'(mb_side_r.py);
      s7_corner_r <= mb_side_r.corner;
    end
  end

  // ---------------- output register with saturation ----------------
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sh8000_0000);

  logic signed [DATA_W-1:0] vx_nxt, vy_nxt;
  logic signed [DATA_W-1:0] out_x_r, out_y_r;
  corner_t                  out_corner_r;

  always_comb begin
    if (s7_rx_r > SAT_HI)      vx_nxt = DATA_W'(SAT_HI);
    else if (s7_rx_r < SAT_LO) vx_nxt = DATA_W'(SAT_LO);
    else                       vx_nxt = DATA_W'(s7_rx_r);
    if (s7_ry_r > SAT_HI)      vy_nxt = DATA_W'(SAT_HI);
    else if (s7_ry_r < SAT_LO) vy_nxt = DATA_W'(SAT_LO);
    else                       vy_nxt = DATA_W'(s7_ry_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= s7_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r      <= vx_nxt;
      out_y_r      <= vy_nxt;
      out_corner_r <= s7_corner_r;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.vertex_x = out_x_r;
  assign out_ch.vertex_y = out_y_r;
  assign out_ch.corner   = out_corner_r;
  assign out_ch.last     = (out_corner_r == LAST_CORNER);

endmodule

// ===== tb/sv/sprite_quad_vertex_gen_core_tb.sv =====
module sprite_quad_vertex_gen_core_tb;
  import sqvg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Must match the dut instance below.
  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int STEPS  = CORDIC_STEPS_DEF;
  localparam int NSTEPS = (STEPS < MAX_STEPS) ? STEPS : MAX_STEPS;

  // Settle time after the last beat, per the pipeline depth.
  localparam int DRAIN_CYC = STEPS + 9 + 40;
  localparam int MAX_CYC   = 200000;

  // Cycle window with no idling on either side.
  localparam int QUIET_LO = 250;
  localparam int QUIET_HI = 450;

  typedef struct {
    logic signed [DATA_W-1:0] pos_x, pos_y, size_x, size_y;
    logic signed [DATA_W-1:0] pivot_x, pivot_y, angle_deg;
  } sprite_t;

  typedef struct {
    logic signed [DATA_W-1:0] vertex_x, vertex_y;
    corner_t                  corner;
    logic                     last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle = 0;
  int   errors = 0;

  sprite_t sprite_q[$];
  vertex_t vertex_q[$];

  sqvg_in_if  in_ch ();
  sqvg_out_if out_ch ();

  sprite_quad_vertex_gen_core #(
    .FRAC_BITS   (FRAC),
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYC) begin
      $display("%0t timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact integer arithmetic in 64 bits, 96 bits for trig products.
  // ---------------------------------------------------------------------------

  // Round Q.2F to Q.F: add half, floor shift.
  function automatic longint rnd_frac(longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // Q.F times Q2.30, rounded half away from zero.
  function automatic longint trig_mul(longint d, longint t);
    logic        neg;
    logic [95:0] m, n, p;
    neg = (d < 0) != (t < 0);
    m = (d < 0) ? 96'(-d) : 96'(d);
    n = (t < 0) ? 96'(-t) : 96'(t);
    p = (m * n + (96'd1 << 29)) >> 30;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  task automatic sin_cos_of(input logic signed [DATA_W-1:0] ang,
                            output longint cs, output longint sn);
    longint      period, a, x, y, z, nx;
    logic [63:0] t64;
    logic [31:0] turn;
    quad_t       q;
    period = 64'sd360 <<< FRAC;
    a = longint'(ang) % period;
    if (a < 0) a += period;
    t64 = ((64'(a) << (32 - FRAC)) + 64'd180) / 64'd360;
    turn = t64[31:0];
    q = quad_t'(turn[31:30]);
    x = longint'(CORDIC_K);
    y = 0;
    z = longint'(turn[29:0]);
    for (int i = 0; i < NSTEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(atan_turn(i));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(atan_turn(i));
      end
      x = nx;
    end
    case (q)
      QUAD_0:  begin cs = x;  sn = y;  end
      QUAD_1:  begin cs = -y; sn = x;  end
      QUAD_2:  begin cs = -x; sn = -y; end
      default: begin cs = y;  sn = -x; end
    endcase
  endtask

  task automatic predict_corners(input sprite_t s);
    longint  px, py, wx, wy, ox2, oy2, ox, oy, cs, sn, half, dx, dy, rx, ry;
    longint  sgx, sgy;
    vertex_t v;
    px = s.pos_x;   py = s.pos_y;
    wx = s.size_x;  wy = s.size_y;
    ox2 = longint'(s.pivot_x) * wx;
    oy2 = longint'(s.pivot_y) * wy;
    ox = rnd_frac(ox2);
    oy = rnd_frac(oy2);
    half = 64'sd1 <<< (FRAC - 1);
    sin_cos_of(s.angle_deg, cs, sn);
    // corner order (-,-), (+,-), (+,+), (-,+)
    for (int k = 0; k < 4; k++) begin
      sgx = (k == 0 || k == 3) ? -1 : 1;
      sgy = (k < 2) ? -1 : 1;
      dx = rnd_frac(sgx * wx * half - ox2);
      dy = rnd_frac(sgy * wy * half - oy2);
      rx = trig_mul(dx, cs) - trig_mul(dy, sn) + ox + px;
      ry = trig_mul(dx, sn) + trig_mul(dy, cs) + oy + py;
      v.vertex_x = sat_q(rx);
      v.vertex_y = sat_q(ry);
      v.corner   = corner_t'(k);
      v.last     = (corner_t'(k) == LAST_CORNER);
      vertex_q.insert(vertex_q.size(), v);
    end
  endtask

  function automatic logic idle_now();
    if (cycle >= QUIET_LO && cycle < QUIET_HI) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one sprite beat per handshake, random bubbles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sprite_t s;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s.pos_x = in_ch.pos_x;     s.pos_y = in_ch.pos_y;
        s.size_x = in_ch.size_x;   s.size_y = in_ch.size_y;
        s.pivot_x = in_ch.pivot_x; s.pivot_y = in_ch.pivot_y;
        s.angle_deg = in_ch.angle_deg;
        predict_corners(s);
      end
      // Load the next beat once the current one is gone (or none held).
      if (!in_ch.valid || in_ch.ready) begin
        if (sprite_q.size() > 0 && !idle_now()) begin
          s = sprite_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.pos_x     <= s.pos_x;
          in_ch.pos_y     <= s.pos_y;
          in_ch.size_x    <= s.size_x;
          in_ch.size_y    <= s.size_y;
          in_ch.pivot_x   <= s.pivot_x;
          in_ch.pivot_y   <= s.pivot_y;
          in_ch.angle_deg <= s.angle_deg;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, compare each corner beat in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_now();
      if (out_ch.valid && out_ch.ready) begin
        if (vertex_q.size() == 0) begin
          $display("%0t unexpected beat: x=%0d y=%0d corner=%0d last=%0b", $time,
                   out_ch.vertex_x, out_ch.vertex_y, out_ch.corner, out_ch.last);
          errors <= errors + 1;
        end else begin
          e = vertex_q.pop_front();
          if (out_ch.vertex_x !== e.vertex_x || out_ch.vertex_y !== e.vertex_y ||
              out_ch.corner !== e.corner || out_ch.last !== e.last) begin
            $display("%0t mismatch: expected x=%0d y=%0d corner=%0d last=%0b", $time,
                     e.vertex_x, e.vertex_y, e.corner, e.last);
            $display("%0t           actual   x=%0d y=%0d corner=%0d last=%0b", $time,
                     out_ch.vertex_x, out_ch.vertex_y, out_ch.corner, out_ch.last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] q_of(int whole);
    return 32'(whole) <<< FRAC;
  endfunction

  task automatic add_sprite(input logic signed [31:0] px, py, wx, wy, vx, vy, ang);
    sprite_t s;
    s.pos_x = px;   s.pos_y = py;
    s.size_x = wx;  s.size_y = wy;
    s.pivot_x = vx; s.pivot_y = vy;
    s.angle_deg = ang;
    sprite_q.insert(sprite_q.size(), s);
  endtask

  function automatic logic signed [31:0] rnd32();
    return $urandom;
  endfunction

  initial begin
    logic signed [31:0] hq, mx, mn;
    hq = 32'sd1 <<< (FRAC - 1);   // 0.5
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;

    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;   in_ch.pos_y = '0;
    in_ch.size_x = '0;  in_ch.size_y = '0;
    in_ch.pivot_x = '0; in_ch.pivot_y = '0;
    in_ch.angle_deg = '0;
    out_ch.ready = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: axis angles, wrapped angles, extreme operands.
    add_sprite(0, 0, 0, 0, 0, 0, 0);
    add_sprite(q_of(10), q_of(20), q_of(4), q_of(2), hq, hq, 0);
    add_sprite(q_of(10), q_of(20), q_of(4), q_of(2), hq, hq, q_of(90));
    add_sprite(q_of(10), q_of(20), q_of(4), q_of(2), 0, 0, q_of(180));
    add_sprite(q_of(10), q_of(20), q_of(4), q_of(2), 0, 0, q_of(270));
    add_sprite(q_of(-5), q_of(3), q_of(8), q_of(6), 0, q_of(1), q_of(-90));
    add_sprite(q_of(1), q_of(1), q_of(3), q_of(3), 0, 0, q_of(765));      // 720 + 45
    add_sprite(q_of(1), q_of(1), q_of(3), q_of(3), 0, 0, q_of(-1035));
    add_sprite(q_of(1), q_of(1), q_of(3), q_of(3), 0, 0, q_of(360));
    add_sprite(q_of(1), q_of(1), q_of(3), q_of(3), 0, 0, q_of(360) - 1);
    add_sprite(0, 0, q_of(2), q_of(2), 0, 0, mx);                         // angle extremes
    add_sprite(0, 0, q_of(2), q_of(2), 0, 0, mn);
    add_sprite(mx, mx, mx, mx, mx, mx, q_of(30));                        // saturate high
    add_sprite(mn, mn, mn, mn, mn, mn, q_of(30));                        // pivot*size = 2^62
    add_sprite(mn, mx, mx, mn, mn, mx, q_of(135));
    add_sprite(mx, mn, mn, mx, mx, mn, q_of(225));
    add_sprite(mx, mx, q_of(100), q_of(100), 0, 0, 0);
    add_sprite(mn, mn, q_of(100), q_of(100), 0, 0, q_of(180));
    add_sprite(q_of(7), q_of(-7), q_of(-16), q_of(-9), q_of(-1), q_of(2), q_of(60));
    add_sprite(-1, 1, 1, -1, -1, 1, 1);                                  // lsb-sized
    add_sprite(32'sh55555555, 32'shaaaaaaaa, 32'sh00550055, 32'sh00aa00aa,
               32'sh00005555, 32'shffffaaaa, 32'sh5555aaaa);

    // Random: mostly realistic sprites, some full-range noise.
    for (int n = 0; n < 130; n++) begin
      if ($urandom_range(3) == 0)
        add_sprite(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
      else
        add_sprite(32'($signed($urandom_range(2000 << FRAC)) - (1000 <<< FRAC)),
                   32'($signed($urandom_range(2000 << FRAC)) - (1000 <<< FRAC)),
                   32'($signed($urandom_range(512 << FRAC)) - (256 <<< FRAC)),
                   32'($signed($urandom_range(512 << FRAC)) - (256 <<< FRAC)),
                   32'($signed($urandom_range(3 << FRAC)) - (1 <<< FRAC)),
                   32'($signed($urandom_range(3 << FRAC)) - (1 <<< FRAC)),
                   32'($signed($urandom_range(1440 << FRAC)) - (720 <<< FRAC)));
    end

    wait (sprite_q.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (vertex_q.size() != 0) begin
      $display("%0t %0d corner beats never arrived", $time, vertex_q.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
